### hw/rtl/cdh_pkg.sv
// Shared types and constants for the two-key chord detector.
package cdh_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLAY       = 1'd1;

  // Configuration reset values.
  localparam logic [CFG_DATA_W-1:0] WINDOW_TICKS_RESET = 16'd150;
  localparam logic                  REPLAY_RESET       = 1'b1;

  // Request command codes.
  localparam logic [1:0] CMD_VOLUME = 2'd0;
  localparam logic [1:0] CMD_POWER  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Key level codes.
  localparam logic [1:0] LVL_RELEASE = 2'd0;
  localparam logic [1:0] LVL_PRESS   = 2'd1;
  localparam logic [1:0] LVL_REPEAT  = 2'd2;

  // Most results kept for one request; any further ones are dropped.
  localparam int MAX_RES = 3;

  typedef enum logic [1:0] {
    ACT_REPLAY  = 2'd0,
    ACT_COMBO   = 2'd1,
    ACT_TAKE    = 2'd2,
    ACT_RELEASE = 2'd3
  } cdh_action_t;

  // Chord tracking flags.
  typedef struct packed {
    logic volume_is_down;
    logic power_is_down;
    logic press_pending;
    logic press_forwarded;
    logic already_fired;
    logic power_taken;
    logic window_running;
  } cdh_flags_t;

  typedef struct packed {
    cdh_action_t action;
    logic [1:0]  key_value;
  } cdh_result_t;

  // The kept results of one request, in order, with their count.
  typedef struct packed {
    cdh_result_t [MAX_RES-1:0] res;
    logic [1:0]                count;
  } cdh_group_t;

endpackage

### hw/rtl/cdh_eval.sv
// Single-pass evaluation of one request: next chord state and its result group.
module cdh_eval #(
  parameter int WINDOW_BITS = 16
) (
  input  cdh_pkg::cdh_flags_t              flags_i,
  input  logic [WINDOW_BITS-1:0]           left_i,
  input  logic [1:0]                       cmd_i,
  input  logic [1:0]                       level_i,
  input  logic                             power_now_i,
  input  logic [cdh_pkg::CFG_DATA_W-1:0]   window_ticks_i,
  input  logic                             replay_i,
  output cdh_pkg::cdh_flags_t              flags_o,
  output logic [WINDOW_BITS-1:0]           left_o,
  output cdh_pkg::cdh_group_t              grp_o
);

  localparam logic [WINDOW_BITS-1:0] WIN_MAX = '1;

  logic [WINDOW_BITS-1:0] win_load;

  // Append one result to a group; results past the buffer depth are dropped.
  function automatic cdh_pkg::cdh_group_t push(input cdh_pkg::cdh_group_t g,
                                               input cdh_pkg::cdh_action_t a,
                                               input logic [1:0] v);
    cdh_pkg::cdh_group_t r;
    r = g;
    if (r.count < 2'(cdh_pkg::MAX_RES)) begin
      r.res[r.count].action    = a;
      r.res[r.count].key_value = v;
      r.count                  = r.count + 2'd1;
    end
    return r;
  endfunction

  // Window reload: zero acts as one, and values beyond the counter saturate.
  always_comb begin
    if (WINDOW_BITS >= cdh_pkg::CFG_DATA_W) begin
      win_load = WINDOW_BITS'(window_ticks_i);
    end else if (window_ticks_i > cdh_pkg::CFG_DATA_W'(WIN_MAX)) begin
      win_load = WIN_MAX;
    end else begin
      win_load = WINDOW_BITS'(window_ticks_i);
    end
    if (window_ticks_i == '0) begin
      win_load = WINDOW_BITS'(1);
    end
  end

  // Request decode and state update, in the order the events take effect.
  always_comb begin
    cdh_pkg::cdh_flags_t    f;
    logic [WINDOW_BITS-1:0] left;
    cdh_pkg::cdh_group_t    g;
    logic                   was_down;
    logic                   chk_both;

    f        = flags_i;
    left     = left_i;
    g        = '0;
    was_down = flags_i.volume_is_down;
    chk_both = 1'b0;

    unique case (cmd_i)
      cdh_pkg::CMD_VOLUME: begin
        f.volume_is_down = (level_i != cdh_pkg::LVL_RELEASE);
        chk_both         = 1'b1;

        // Volume press edge: grab power; if power is down now, fire once and give power back.
        if (f.volume_is_down && !was_down) begin
          if (!f.power_taken) begin
            f.power_taken = 1'b1;
            g = push(g, cdh_pkg::ACT_TAKE, cdh_pkg::LVL_RELEASE);
          end
          if (power_now_i) begin
            if (!f.already_fired) begin
              f.already_fired = 1'b1;
              if (f.press_pending) begin
                f.window_running = 1'b0;
                f.press_pending  = 1'b0;
              end
              g = push(g, cdh_pkg::ACT_COMBO, cdh_pkg::LVL_RELEASE);
            end
            f.power_taken   = 1'b0;
            g = push(g, cdh_pkg::ACT_RELEASE, cdh_pkg::LVL_RELEASE);
            f.power_is_down = 1'b0;
          end
        end

        // Hold-back and replay of the volume key.
        if (replay_i) begin
          case (level_i)
            cdh_pkg::LVL_PRESS: begin
              f.press_pending   = 1'b1;
              f.press_forwarded = 1'b0;
              left              = win_load;
              f.window_running  = 1'b1;
            end
            cdh_pkg::LVL_REPEAT: begin
              if (f.press_forwarded) begin
                g = push(g, cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_REPEAT);
              end
            end
            default: begin
              f.window_running = 1'b0;
              if (f.press_pending) begin
                g = push(g, cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_PRESS);
                g = push(g, cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_RELEASE);
                f.press_pending = 1'b0;
              end else if (f.press_forwarded) begin
                g = push(g, cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_RELEASE);
                f.press_forwarded = 1'b0;
              end
            end
          endcase
        end
      end
      cdh_pkg::CMD_POWER: begin
        f.power_is_down = (level_i != cdh_pkg::LVL_RELEASE);
        chk_both        = 1'b1;
      end
      cdh_pkg::CMD_TICK: begin
        // Window countdown; on expiry the held press is forwarded.
        if (f.window_running) begin
          if (left > WINDOW_BITS'(1)) begin
            left = left - WINDOW_BITS'(1);
          end else begin
            left             = '0;
            f.window_running = 1'b0;
            if (f.press_pending) begin
              f.press_pending   = 1'b0;
              f.press_forwarded = 1'b1;
              g = push(g, cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_PRESS);
            end
          end
        end
      end
      default: begin
      end
    endcase

    // Chord check, then give power back once both keys are up.
    if (chk_both) begin
      if (f.volume_is_down && f.power_is_down && !f.already_fired) begin
        f.already_fired = 1'b1;
        if (f.press_pending) begin
          f.window_running = 1'b0;
          f.press_pending  = 1'b0;
        end
        g = push(g, cdh_pkg::ACT_COMBO, cdh_pkg::LVL_RELEASE);
      end
      if (!f.volume_is_down && !f.power_is_down) begin
        f.already_fired = 1'b0;
        if (f.power_taken) begin
          f.power_taken = 1'b0;
          g = push(g, cdh_pkg::ACT_RELEASE, cdh_pkg::LVL_RELEASE);
        end
      end
    end

    flags_o = f;
    left_o  = left;
    grp_o   = g;
  end

endmodule

### hw/rtl/cdh_drain.sv
// Result buffer for one request; hands out one result per cycle while not stalled.
module cdh_drain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cdh_pkg::cdh_group_t  grp,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_action,
  output logic [1:0]           out_key_value,
  output logic                 out_last
);

  cdh_pkg::cdh_result_t [cdh_pkg::MAX_RES-1:0] ent_r;
  logic [1:0] cnt_r;
  logic [1:0] ptr_r;
  logic       busy;
  logic       take;
  logic       at_last;

  // Buffer status and the result shown to the consumer.
  assign busy          = (ptr_r < cnt_r);
  assign at_last       = ((ptr_r + 2'd1) == cnt_r);
  assign take          = busy && !out_stall;
  assign can_load      = !busy || (take && at_last);
  assign out_valid     = busy;
  assign out_action    = ent_r[ptr_r].action;
  assign out_key_value = ent_r[ptr_r].key_value;
  assign out_last      = at_last;

  // Control: count and read pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (load) begin
      cnt_r <= grp.count;
      ptr_r <= '0;
    end else if (take) begin
      ptr_r <= ptr_r + 2'd1;
    end
  end

  // Payload: results of the request being drained.
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= grp.res;
    end
  end

endmodule

### hw/rtl/two_key_chord_detector_with_holdback.sv
// A request waits in the input register until its group is loaded into the result buffer.
// Throughput: one request per cycle while each causes at most one result and out_stall is low.
// A request with k results holds the three-entry result buffer until all k are taken.
// While results wait, the input register takes one more request and then the input stalls.
// Reset (rst_n low, synchronous) clears all chord state and loads window 150, replay on.
// No clearing pass: the block takes requests from the first cycle after reset.
module two_key_chord_detector_with_holdback #(
  parameter int WINDOW_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic [1:0]                          in_level,
  input  logic                                in_power_now,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_action,
  output logic [1:0]                          out_key_value,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [cdh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cdh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [cdh_pkg::CFG_DATA_W-1:0] window_ticks_r;
  logic                           replay_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [1:0] s1_cmd_r;
  logic [1:0] s1_level_r;
  logic       s1_power_r;

  cdh_pkg::cdh_flags_t    flags_r;
  cdh_pkg::cdh_flags_t    flags_nxt;
  logic [WINDOW_BITS-1:0] left_r;
  logic [WINDOW_BITS-1:0] left_nxt;
  cdh_pkg::cdh_group_t    grp;

  logic can_load;
  logic fire;
  logic in_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= cdh_pkg::WINDOW_TICKS_RESET;
      replay_r       <= cdh_pkg::REPLAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdh_pkg::REG_WINDOW_TICKS: window_ticks_r <= cfg_data;
        cdh_pkg::REG_REPLAY:       replay_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register handshake: evaluate when the result buffer can take a group.
  assign fire         = s1_valid_r && can_load;
  assign in_stall     = s1_valid_r && !can_load;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_cmd;
      s1_level_r <= in_level;
      s1_power_r <= in_power_now;
    end
  end

  // Request evaluation.
  cdh_eval #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_eval (
    .flags_i        (flags_r),
    .left_i         (left_r),
    .cmd_i          (s1_cmd_r),
    .level_i        (s1_level_r),
    .power_now_i    (s1_power_r),
    .window_ticks_i (window_ticks_r),
    .replay_i       (replay_r),
    .flags_o        (flags_nxt),
    .left_o         (left_nxt),
    .grp_o          (grp)
  );

  // Chord state advances once per evaluated request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      left_r  <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      left_r  <= left_nxt;
    end
  end

  // Result buffer and output channel.
  cdh_drain u_drain (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (fire),
    .grp           (grp),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_key_value (out_key_value),
    .out_last      (out_last)
  );

`ifndef NO_ASSERTIONS
  // A held press always has its window running.
  a_pending_has_window: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.press_pending |-> flags_r.window_running)
    else $error("press held back without a running window");

  // A press is never both held back and already forwarded.
  a_pending_xor_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    !(flags_r.press_pending && flags_r.press_forwarded))
    else $error("press both pending and forwarded");

  // A running window never sits at zero ticks.
  a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.window_running |-> (left_r != '0))
    else $error("window running with zero ticks left");

  // A request that waits in the input register is evaluated once the buffer frees.
  a_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && can_load && !in_take) |=> !s1_valid_r)
    else $error("evaluated request left in the input register");
`endif

endmodule

### bench/tb_top.sv
// Self-checking testbench for the two-key chord detector with volume hold-back.
`timescale 1ns / 100ps

module tb_top;

  // Codes that the package leaves unnamed but the request fields can carry.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] LVL_ODD    = 2'd3;

  localparam int RANDOM_REQS  = 280;
  localparam int PHASES       = 7;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] level;
    logic       power_now;
  } key_req_t;

  typedef struct packed {
    cdh_pkg::cdh_action_t action;
    logic [1:0]           key_value;
    logic                 last;
  } chord_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_cmd = '0;
  logic [1:0]                     in_level = '0;
  logic                           in_power_now = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     out_action;
  logic [1:0]                     out_key_value;
  logic                           out_last;
  logic                           cfg_we = 1'b0;
  logic [cdh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cdh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  key_req_t   key_requests_q [$];
  chord_res_t due_results [$];
  int         errors = 0;
  int         cycles = 0;

  // Shadow of the configuration registers.
  logic [15:0] win_setting;
  logic        replay_on;

  // Shadow of the chord state.
  logic        vol_held, pwr_held, press_held_back, press_sent;
  logic        combo_done, pwr_grabbed, win_active;
  logic [15:0] win_count;

  // Results of the request being predicted.
  cdh_pkg::cdh_action_t step_act [3];
  logic [1:0]           step_val [3];
  int                   step_n;

  two_key_chord_detector_with_holdback dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_level     (in_level),
    .in_power_now (in_power_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_action   (out_action),
    .out_key_value(out_key_value),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results past the third one of a request are dropped.
  task automatic note_result(input cdh_pkg::cdh_action_t act, input logic [1:0] val);
    if (step_n < 3) begin
      step_act[step_n] = act;
      step_val[step_n] = val;
      step_n++;
    end
  endtask

  // Taking or releasing the power key reports only a real change.
  task automatic grab_power(input logic on);
    if (on != pwr_grabbed) begin
      pwr_grabbed = on;
      if (on) begin
        note_result(cdh_pkg::ACT_TAKE, 2'd0);
      end else begin
        note_result(cdh_pkg::ACT_RELEASE, 2'd0);
      end
    end
  endtask

  task automatic fire_chord();
    if (!combo_done) begin
      combo_done = 1'b1;
      if (press_held_back) begin
        win_active = 1'b0;
        press_held_back = 1'b0;
      end
      note_result(cdh_pkg::ACT_COMBO, 2'd0);
    end
  endtask

  task automatic drop_if_both_up();
    if (!vol_held && !pwr_held) begin
      combo_done = 1'b0;
      grab_power(1'b0);
    end
  endtask

  task automatic volume_event(input logic [1:0] level, input logic live);
    logic was_held;
    was_held = vol_held;
    vol_held = (level != cdh_pkg::LVL_RELEASE);
    // A new volume press grabs power; the late case fires and lets go at once.
    if (vol_held && !was_held) begin
      grab_power(1'b1);
      if (pwr_grabbed && live) begin
        pwr_held = 1'b1;
        fire_chord();
        grab_power(1'b0);
        pwr_held = 1'b0;
      end
    end
    // Hold-back and replay of the volume key.
    if (replay_on) begin
      if (level == cdh_pkg::LVL_PRESS) begin
        press_held_back = 1'b1;
        press_sent = 1'b0;
        win_count = (win_setting == 16'd0) ? 16'd1 : win_setting;
        win_active = 1'b1;
      end else if (level == cdh_pkg::LVL_REPEAT) begin
        if (press_sent) note_result(cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_REPEAT);
      end else begin
        win_active = 1'b0;
        if (press_held_back) begin
          note_result(cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_PRESS);
          note_result(cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_RELEASE);
          press_held_back = 1'b0;
        end else if (press_sent) begin
          note_result(cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_RELEASE);
          press_sent = 1'b0;
        end
      end
    end
    if (vol_held && pwr_held) fire_chord();
    drop_if_both_up();
  endtask

  task automatic tick_event();
    if (win_active) begin
      if (win_count > 16'd1) begin
        win_count = win_count - 16'd1;
      end else begin
        // Window expired: a still held-back press goes out now.
        win_count = 16'd0;
        win_active = 1'b0;
        if (press_held_back) begin
          press_held_back = 1'b0;
          press_sent = 1'b1;
          note_result(cdh_pkg::ACT_REPLAY, cdh_pkg::LVL_PRESS);
        end
      end
    end
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic predict_chord_results(input key_req_t req);
    chord_res_t r;
    step_n = 0;
    case (req.cmd)
      cdh_pkg::CMD_VOLUME: volume_event(req.level, req.power_now);
      cdh_pkg::CMD_POWER: begin
        pwr_held = (req.level != cdh_pkg::LVL_RELEASE);
        if (pwr_held && vol_held) fire_chord();
        drop_if_both_up();
      end
      cdh_pkg::CMD_TICK: tick_event();
      default: ;
    endcase
    for (int i = 0; i < step_n; i++) begin
      r.action = step_act[i];
      r.key_value = step_val[i];
      r.last = (i == step_n - 1);
      due_results.push_back(r);
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  key_req_t drv_req;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_req.cmd = in_cmd;
        drv_req.level = in_level;
        drv_req.power_now = in_power_now;
        predict_chord_results(drv_req);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (key_requests_q.size() > 0) begin
          drv_req = key_requests_q.pop_front();
          in_cmd <= drv_req.cmd;
          in_level <= drv_req.level;
          in_power_now <= drv_req.power_now;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap_left = $urandom_range(0, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall: stretches of no stall, random stall and solid stall.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(4, 30);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Result monitor: each accepted result against the oldest one due.
  chord_res_t mon_due;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual action %0d value %0d last %0d",
                 $time, out_action, out_key_value, out_last);
        errors++;
      end else begin
        mon_due = due_results.pop_front();
        if (out_action !== mon_due.action) begin
          $display("%0t: action mismatch: expected %0d, actual %0d",
                   $time, mon_due.action, out_action);
          errors++;
        end
        if (out_key_value !== mon_due.key_value) begin
          $display("%0t: key_value mismatch: expected %0d, actual %0d",
                   $time, mon_due.key_value, out_key_value);
          errors++;
        end
        if (out_last !== mon_due.last) begin
          $display("%0t: last mismatch: expected %0d, actual %0d",
                   $time, mon_due.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus helpers.
  int  queued = 0;
  logic gen_pwr = 1'b0;

  task automatic add_req(input logic [1:0] cmd, input logic [1:0] level, input logic pnow);
    key_req_t req;
    req.cmd = cmd;
    req.level = level;
    req.power_now = pnow;
    key_requests_q.push_back(req);
    queued++;
    if (cmd == cdh_pkg::CMD_POWER) gen_pwr = (level != cdh_pkg::LVL_RELEASE);
  endtask

  // Ticks carry random, ignored level and power fields.
  task automatic add_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      add_req(cdh_pkg::CMD_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle();
    while (key_requests_q.size() != 0 || in_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] window, input logic replay);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= cdh_pkg::REG_WINDOW_TICKS;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= cdh_pkg::REG_REPLAY;
    cfg_data <= {15'($urandom), replay};
    @(posedge clk);
    cfg_we <= 1'b0;
    win_setting = window;
    replay_on = replay;
  endtask

  // One random gesture: mostly well-formed chords and taps, some noise.
  task automatic add_gesture();
    int kind;
    int max_ticks;
    int n;
    kind = $urandom_range(0, 9);
    max_ticks = (win_setting > 16'd12) ? 6 : int'(win_setting) + 2;
    if (kind <= 2) begin
      // Volume tap, maybe long enough to replay and repeat.
      add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, gen_pwr);
      add_ticks($urandom_range(0, max_ticks));
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_REPEAT, gen_pwr);
        if ($urandom_range(0, 1)) add_ticks(1);
      end
      add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, gen_pwr);
    end else if (kind <= 5) begin
      // Volume first, then power within or after the window.
      add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, gen_pwr);
      add_ticks($urandom_range(0, max_ticks));
      add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_REPEAT, gen_pwr);
      if ($urandom_range(0, 2) == 0) begin
        add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_REPEAT, 1'($urandom_range(0, 1)));
      end
      add_ticks($urandom_range(0, 2));
      if ($urandom_range(0, 1)) begin
        add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'($urandom_range(0, 1)));
        add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, gen_pwr);
      end else begin
        add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, gen_pwr);
        add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'($urandom_range(0, 1)));
      end
    end else if (kind <= 7) begin
      // Late case: power already down when volume goes down.
      add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'($urandom_range(0, 1)));
      add_ticks($urandom_range(0, 2));
      add_req(cdh_pkg::CMD_VOLUME,
              ($urandom_range(0, 3) == 0) ? cdh_pkg::LVL_REPEAT : cdh_pkg::LVL_PRESS,
              gen_pwr);
      add_ticks($urandom_range(0, max_ticks));
      if ($urandom_range(0, 1)) begin
        add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'($urandom_range(0, 1)));
        add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, gen_pwr);
      end else begin
        add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, gen_pwr);
        add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'($urandom_range(0, 1)));
      end
    end else begin
      // Noise over the whole field space.
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        add_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  logic [15:0] phase_window [PHASES] = '{16'd5, 16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd3, 16'hFFFF};
  logic        phase_replay [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    win_setting = cdh_pkg::WINDOW_TICKS_RESET;
    replay_on = cdh_pkg::REPLAY_RESET;
    {vol_held, pwr_held, press_held_back, press_sent} = '0;
    {combo_done, pwr_grabbed, win_active} = '0;
    win_count = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: chord inside the window cancels the held press.
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, 1'b0);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_REPEAT, 1'b0);
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'b0);
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'b1);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b1);
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'b0);
    add_req(CMD_UNUSED, LVL_ODD, 1'b1);
    wait_idle();

    write_config(16'd2, 1'b1);
    // Window expiry, then repeat and release after forwarding.
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, 1'b0);
    add_ticks(2);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_REPEAT, 1'b0);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b0);
    // Late case.
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'b0);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, 1'b1);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b1);
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'b1);
    // Autorepeat with the key up counts as a press edge.
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_REPEAT, 1'b0);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b0);
    // Early release replays a press and release pair.
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_PRESS, 1'b0);
    add_ticks(1);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b0);
    // Level three is down for power but a release for hold-back.
    add_req(cdh_pkg::CMD_VOLUME, LVL_ODD, 1'b0);
    add_req(cdh_pkg::CMD_VOLUME, cdh_pkg::LVL_RELEASE, 1'b0);
    // Power events while the power key is not taken.
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_PRESS, 1'b1);
    add_req(cdh_pkg::CMD_POWER, cdh_pkg::LVL_RELEASE, 1'b0);
    wait_idle();

    // Random phases over several register settings.
    for (int p = 0; p < PHASES; p++) begin
      write_config(phase_window[p], phase_replay[p]);
      queued = 0;
      while (queued < RANDOM_REQS / PHASES) add_gesture();
      wait_idle();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### two_key_chord_detector_with_holdback.f
hw/rtl/cdh_pkg.sv
hw/rtl/cdh_eval.sv
hw/rtl/cdh_drain.sv
hw/rtl/two_key_chord_detector_with_holdback.sv
bench/tb_top.sv
